// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/hgc_pkg.sv
// shared constants, tables and helpers of the haversine geofence pipeline
package hgc_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int DIST_W = 25;
    localparam int RAD_W  = 25;
    localparam int CFG_W  = 32;

    localparam logic [1:0] CFG_CLAT = 2'd0;
    localparam logic [1:0] CFG_CLON = 2'd1;
    localparam logic [1:0] CFG_RAD  = 2'd2;

    localparam logic signed [LAT_W-1:0] RST_CLAT = 31'sd377749000;
    localparam logic signed [LON_W-1:0] RST_CLON = -32'sd1224194000;
    localparam logic [RAD_W-1:0]        RST_RAD  = 25'd50000;

    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;
    localparam logic [32:0] TURN_E7      = 33'd3600000000;
    localparam logic [32:0] HALF_TURN_E7 = 33'd1800000000;
    localparam logic [33:0] TWO_TURN_E7  = 34'd7200000000;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    // floor of pi_q30 * 2^32 / full turn, never above the true ratio
    localparam logic [31:0] RAD_K = 32'((PI_Q30 << 32) / 64'd3600000000);

    localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;
    localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam logic [23:0]        EARTH_2R_M   = 24'd12742000;
    localparam logic [56:0]        DIST_ROUND   = 57'h2000_0000;
    localparam logic [DIST_W-1:0]  DIST_MAX     = 25'd20038000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    function automatic logic signed [LAT_W-1:0] clamp_lat(input logic signed [LAT_W-1:0] v);
        logic signed [LAT_W-1:0] res;
        res = v;
        if (v > LAT_LIMIT) begin
            res = LAT_LIMIT;
        end else if (v < -LAT_LIMIT) begin
            res = -LAT_LIMIT;
        end
        return res;
    endfunction

    function automatic logic [30:0] clamp_q30(input logic signed [32:0] v);
        logic [30:0] res;
        res = v[30:0];
        if (v[32]) begin
            res = '0;
        end else if (v > $signed({2'b00, ONE_Q30})) begin
            res = ONE_Q30;
        end
        return res;
    endfunction

endpackage

// File: sv/hgc_in_if.sv
// position channel: latitude and longitude beats
interface hgc_in_if;
    import hgc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    modport source (output valid, output latitude, output longitude, input ready);
    modport sink   (input valid, input latitude, input longitude, output ready);
endinterface

// File: sv/hgc_out_if.sv
// result channel: inside flag and distance beats
interface hgc_out_if;
    import hgc_pkg::*;
    logic              valid;
    logic              ready;
    logic              inside_res;
    logic [DIST_W-1:0] distance_m;
    modport source (output valid, output inside_res, output distance_m, input ready);
    modport sink   (input valid, input inside_res, input distance_m, output ready);
endinterface

// File: sv/hgc_rad.sv
// angle conversion: 1e-7 degree magnitude to q30 half-angle radians, rounded
module hgc_rad (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [30:0] i_mag,
    output logic        o_valid,
    output logic [30:0] o_angle
);
    import hgc_pkg::*;

    logic [2:0]  r_v;
    logic [63:0] r_num;
    logic [30:0] r_qe1;
    logic [30:0] r_qe2;
    logic [33:0] r_rem;
    logic [30:0] r_ang;

    logic [63:0] w_num;
    logic [62:0] w_est;
    logic [63:0] w_prod;
    logic [63:0] w_rem;
    logic [30:0] n_ang;

    // numerator with half-turn rounding term, and a quotient estimate low by 0..2
    assign w_num  = 64'(i_mag) * PI_Q30 + 64'(HALF_TURN_E7);
    assign w_est  = 63'(i_mag) * 63'(RAD_K);
    assign w_prod = 64'(r_qe1) * 64'(TURN_E7);
    assign w_rem  = r_num - w_prod;

    always_comb begin
        if (r_rem >= TWO_TURN_E7) begin
            n_ang = r_qe2 + 31'd2;
        end else if (r_rem >= 34'(TURN_E7)) begin
            n_ang = r_qe2 + 31'd1;
        end else begin
            n_ang = r_qe2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= w_num;
            r_qe1 <= w_est[62:32];
            r_qe2 <= r_qe1;
            r_rem <= w_rem[33:0];
            r_ang <= n_ang;
        end
    end

    assign o_valid = r_v[2];
    assign o_angle = r_ang;

endmodule

// File: sv/hgc_sincos.sv
// rotation cordic, one iteration per stage: sine and cosine of a first-quadrant angle
module hgc_sincos #(
    parameter int STEPS = hgc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [30:0] i_angle,
    output logic        o_valid,
    output logic [30:0] o_sin,
    output logic [30:0] o_cos
);
    import hgc_pkg::*;

    logic [STEPS+1:0]  r_v;
    logic signed [32:0] r_x [0:STEPS];
    logic signed [32:0] r_y [0:STEPS];
    logic signed [32:0] r_z [0:STEPS];
    logic [30:0]       r_sin;
    logic [30:0]       r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= INV_GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= $signed({2'b00, i_angle});
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        logic signed [32:0] w_atan;
        assign w_atan = $signed({1'b0, ATAN_TAB[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_atan;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_atan;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= clamp_q30(r_y[STEPS]);
            r_cos <= clamp_q30(r_x[STEPS]);
        end
    end

    assign o_valid = r_v[STEPS+1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// File: sv/hgc_isqrt.sv
// pipelined restoring square root of a q30 value, one result bit per stage
module hgc_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [30:0] i_val,
    output logic        o_valid,
    output logic [30:0] o_root
);
    localparam int LEVELS = 31;

    logic [LEVELS:0] r_v;
    logic [60:0]     r_rm [0:LEVELS];
    logic [61:0]     r_rt [0:LEVELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LEVELS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rm[0] <= {i_val, 30'd0};
            r_rt[0] <= '0;
        end
    end

    for (genvar k = 0; k < LEVELS; k++) begin : g_level
        localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
        logic [61:0] w_sum;
        assign w_sum = r_rt[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_rm[k]} >= w_sum) begin
                    r_rm[k+1] <= r_rm[k] - w_sum[60:0];
                    r_rt[k+1] <= (r_rt[k] >> 1) + BIT;
                end else begin
                    r_rm[k+1] <= r_rm[k];
                    r_rt[k+1] <= r_rt[k] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[LEVELS];
    assign o_root  = r_rt[LEVELS][30:0];

endmodule

// File: sv/hgc_atan.sv
// vectoring cordic, one iteration per stage: atan2 of two non-negative q30 values
module hgc_atan #(
    parameter int STEPS = hgc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [30:0]        i_ys,
    input  logic [30:0]        i_xs,
    output logic               o_valid,
    output logic signed [32:0] o_angle
);
    import hgc_pkg::*;

    logic [STEPS:0]     r_v;
    logic signed [32:0] r_x [0:STEPS];
    logic signed [32:0] r_y [0:STEPS];
    logic signed [32:0] r_z [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed({2'b00, i_xs});
            r_y[0] <= $signed({2'b00, i_ys});
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        logic signed [32:0] w_atan;
        assign w_atan = $signed({1'b0, ATAN_TAB[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // drive y towards zero
                if (r_y[i] > 33'sd0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_atan;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_atan;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_angle = r_z[STEPS];

endmodule

// File: sv/haversine_geofence_check_top.sv
// top level of the haversine geofence check pipeline
//
//  channel   dir  beat contents
//  i_pos     in   latitude, longitude (1e-7 degree, signed)
//  o_res     out  inside_res, distance_m (metres)
//  i_cfg_*   in   write enable, register index, write data
//
// the latency is set mainly by the two cordic chains and the 31-stage square
// root; one position is taken every cycle while the output is not stalled.
// reset clears all valid bits and loads the default centre and radius.
// a result held at the output freezes the whole pipeline, nothing is dropped
// or repeated, and the position channel is not ready during that stall.
`include "assert_macros.svh"

module haversine_geofence_check_top #(
    parameter int CORDIC_STEPS = hgc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    hgc_in_if.sink                    i_pos,
    hgc_out_if.source                 o_res,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [hgc_pkg::CFG_W-1:0] i_cfg_data
);
    import hgc_pkg::*;

    logic signed [LAT_W-1:0] r_clat;
    logic signed [LON_W-1:0] r_clon;
    logic [RAD_W-1:0]        r_rad;

    logic w_adv;

    // front end
    logic                    r_f1_v;
    logic signed [LAT_W-1:0] r_lat1;
    logic signed [LAT_W-1:0] r_lat2;
    logic signed [31:0]      r_dlat;
    logic signed [32:0]      r_dlon;
    logic                    r_f2_v;
    logic [30:0]             r_mag_dlat;
    logic [30:0]             r_mag_dlon;
    logic [30:0]             r_mag_lat1;
    logic [30:0]             r_mag_lat2;

    logic signed [LAT_W-1:0] w_lat1;
    logic signed [LAT_W-1:0] w_lat2;
    logic [31:0]             w_dlat_abs;
    logic [32:0]             w_dlon_abs;
    logic [32:0]             w_dlon_red;
    logic [32:0]             w_dlon_fold;
    logic [30:0]             w_lat1_abs;
    logic [30:0]             w_lat2_abs;

    // angle and trig
    logic        w_rad_v;
    logic [30:0] w_ang_dlat, w_ang_dlon, w_ang_lat1, w_ang_lat2;
    logic        w_sc_v;
    logic [30:0] w_sl, w_sd;
    logic [30:0] w_c1, w_c2;

    // haversine term
    logic [2:0]  r_mul_v;
    logic [30:0] r_ss;
    logic [30:0] r_cc;
    logic [30:0] r_dd;
    logic [30:0] r_ss2;
    logic [61:0] r_p;
    logic [30:0] r_a;
    logic [30:0] r_na;
    logic [61:0] w_ss;
    logic [61:0] w_cc;
    logic [61:0] w_dd;
    logic [31:0] w_a_sum;

    // roots, angle, distance
    logic               w_sq_v;
    logic [30:0]        w_sq_a;
    logic [30:0]        w_sq_na;
    logic               w_at_v;
    logic signed [32:0] w_z;
    logic [31:0]        w_zc;
    logic               r_d1_v;
    logic [56:0]        r_prod;
    logic [26:0]        w_dist_full;
    logic [DIST_W-1:0]  w_dist;

    logic              r_out_v;
    logic              r_inside;
    logic [DIST_W-1:0] r_dist;

    assign w_adv       = !r_out_v || o_res.ready;
    assign i_pos.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clat <= RST_CLAT;
            r_clon <= RST_CLON;
            r_rad  <= RST_RAD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLAT: r_clat <= i_cfg_data[LAT_W-1:0];
                CFG_CLON: r_clon <= i_cfg_data[LON_W-1:0];
                CFG_RAD:  r_rad  <= i_cfg_data[RAD_W-1:0];
                default:  ;
            endcase
        end
    end

    assign w_lat1 = clamp_lat(i_pos.latitude);
    assign w_lat2 = clamp_lat(r_clat);

    // longitude difference: reduce by a full turn, then fold onto a half turn
    assign w_dlat_abs  = r_dlat[31] ? 32'(-r_dlat) : 32'(r_dlat);
    assign w_dlon_abs  = r_dlon[32] ? 33'(-r_dlon) : 33'(r_dlon);
    assign w_dlon_red  = (w_dlon_abs >= TURN_E7) ? w_dlon_abs - TURN_E7 : w_dlon_abs;
    assign w_dlon_fold = (w_dlon_red > HALF_TURN_E7) ? TURN_E7 - w_dlon_red : w_dlon_red;
    assign w_lat1_abs  = r_lat1[LAT_W-1] ? 31'(-r_lat1) : 31'(r_lat1);
    assign w_lat2_abs  = r_lat2[LAT_W-1] ? 31'(-r_lat2) : 31'(r_lat2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (w_adv) begin
            r_f1_v <= i_pos.valid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lat1     <= w_lat1;
            r_lat2     <= w_lat2;
            r_dlat     <= 32'(w_lat1) - 32'(w_lat2);
            r_dlon     <= 33'(i_pos.longitude) - 33'(r_clon);
            r_mag_dlat <= w_dlat_abs[30:0];
            r_mag_dlon <= w_dlon_fold[30:0];
            // full latitude over a half turn equals twice the value over a full turn
            r_mag_lat1 <= {w_lat1_abs[29:0], 1'b0};
            r_mag_lat2 <= {w_lat2_abs[29:0], 1'b0};
        end
    end

    hgc_rad u_rad_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_f2_v),
        .i_mag(r_mag_dlat), .o_valid(w_rad_v), .o_angle(w_ang_dlat)
    );
    hgc_rad u_rad_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_f2_v),
        .i_mag(r_mag_dlon), .o_valid(), .o_angle(w_ang_dlon)
    );
    hgc_rad u_rad_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_f2_v),
        .i_mag(r_mag_lat1), .o_valid(), .o_angle(w_ang_lat1)
    );
    hgc_rad u_rad_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_f2_v),
        .i_mag(r_mag_lat2), .o_valid(), .o_angle(w_ang_lat2)
    );

    hgc_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_rad_v),
        .i_angle(w_ang_dlat), .o_valid(w_sc_v), .o_sin(w_sl), .o_cos()
    );
    hgc_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_rad_v),
        .i_angle(w_ang_dlon), .o_valid(), .o_sin(w_sd), .o_cos()
    );
    hgc_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_rad_v),
        .i_angle(w_ang_lat1), .o_valid(), .o_sin(), .o_cos(w_c1)
    );
    hgc_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_rad_v),
        .i_angle(w_ang_lat2), .o_valid(), .o_sin(), .o_cos(w_c2)
    );

    // only the half-angle sines and the latitude cosines feed the haversine term
    assign w_ss = 62'(w_sl) * 62'(w_sl);
    assign w_cc = 62'(w_c1) * 62'(w_c2);
    assign w_dd = 62'(w_sd) * 62'(w_sd);
    assign w_a_sum = 32'(r_ss2) + 32'(r_p[60:30]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= '0;
        end else if (w_adv) begin
            r_mul_v <= {r_mul_v[1:0], w_sc_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ss  <= w_ss[60:30];
            r_cc  <= w_cc[60:30];
            r_dd  <= w_dd[60:30];
            r_ss2 <= r_ss;
            r_p   <= 62'(r_cc) * 62'(r_dd);
            if (w_a_sum > 32'(ONE_Q30)) begin
                r_a  <= ONE_Q30;
                r_na <= '0;
            end else begin
                r_a  <= w_a_sum[30:0];
                r_na <= ONE_Q30 - w_a_sum[30:0];
            end
        end
    end

    hgc_isqrt u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_mul_v[2]),
        .i_val(r_a), .o_valid(w_sq_v), .o_root(w_sq_a)
    );
    hgc_isqrt u_sqrt_na (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_mul_v[2]),
        .i_val(r_na), .o_valid(), .o_root(w_sq_na)
    );

    hgc_atan #(.STEPS(CORDIC_STEPS)) u_atan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_sq_v),
        .i_ys(w_sq_a), .i_xs(w_sq_na), .o_valid(w_at_v), .o_angle(w_z)
    );

    // central angle is twice the cordic angle, folded into the radius constant
    assign w_zc        = w_z[32] ? 32'd0 : w_z[31:0];
    assign w_dist_full = r_prod[56:30];
    assign w_dist      = (w_dist_full > 27'(DIST_MAX)) ? DIST_MAX : w_dist_full[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_d1_v  <= w_at_v;
            r_out_v <= r_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod   <= 57'(w_zc) * 57'(EARTH_2R_M) + DIST_ROUND;
            r_dist   <= w_dist;
            r_inside <= (w_dist <= r_rad);
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.inside_res = r_inside;
    assign o_res.distance_m = r_dist;

    `ASSERT_NEVER(a_dist_range, i_clk, i_rst_n, r_out_v && (r_dist > DIST_MAX))
    `ASSERT_CLK(a_inside_flag, i_clk, i_rst_n, r_out_v |-> (r_inside == (r_dist <= r_rad)))

endmodule
